// File: hw/rtl/emg_imj_pkg.sv
// shared constants, register codes and control types for the emg intent rise core
package emg_imj_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 64;

    localparam int ANGLE_W = 16;
    localparam int TICKS_W = 16;
    localparam int THR_W   = 8;
    localparam int CODE_W  = 8;
    localparam int FRAC_W  = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_ANGLE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_TICKS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTENT_THRESHOLD = 2'd2;

    localparam logic [ANGLE_W-1:0] HOLD_ANGLE_RESET       = 16'd3840;
    localparam logic [TICKS_W-1:0] RISE_TICKS_RESET       = 16'd500;
    localparam logic [THR_W-1:0]   INTENT_THRESHOLD_RESET = 8'hcc;

    localparam logic [CODE_W-1:0] CODE_PLANTARFLEX = 8'h00;
    localparam logic [CODE_W-1:0] CODE_DORSIFLEX   = 8'h02;

    // window entries are 2-bit signed: -1, 0, +1
    localparam logic [1:0] WIN_MINUS = 2'b11;
    localparam logic [1:0] WIN_ZERO  = 2'b00;
    localparam logic [1:0] WIN_PLUS  = 2'b01;

    // radix-4 serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MUL_AW = 18;
    localparam int MUL_BW = 20;
    localparam int MUL_HW = MUL_AW + 3;
    localparam int MUL_PW = MUL_HW + MUL_BW;

    localparam logic [FRAC_W:0]   BLEND_ONE  = 17'h10000;
    localparam logic [MUL_BW:0]   Q_BASE     = 21'd655360;
    localparam logic [2*FRAC_W-1:0] ROUND_HALF = 32'h0000_8000;

    typedef struct packed {
        logic       clear;
        logic       advance;
        logic       update;
        logic [1:0] value;
    } win_ctrl_t;

endpackage

// File: hw/rtl/emg_imj_window.sv
// circular intent window with running sum, fill flag instead of clearing the memory
module emg_imj_window #(
    parameter int WINDOW_DEPTH = emg_imj_pkg::DEFAULT_WINDOW_DEPTH,
    localparam int SUM_W = $clog2(WINDOW_DEPTH + 1) + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  emg_imj_pkg::win_ctrl_t  ctrl,
    output logic signed [SUM_W-1:0] sum
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

    logic [1:0]       mem [WINDOW_DEPTH];
    logic [1:0]       rd_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next, ptr_adv;
    logic             full_reg, full_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [1:0]       old_value;

    assign ptr_adv   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
    // entries ahead of the write point hold nothing until the first wrap
    assign old_value = full_reg ? rd_reg : emg_imj_pkg::WIN_ZERO;

    always_comb begin
        ptr_next  = ptr_reg;
        full_next = full_reg;
        sum_next  = sum_reg;
        if (ctrl.clear) begin
            ptr_next  = PTR_LAST;
            full_next = 1'b0;
            sum_next  = '0;
        end else if (ctrl.advance) begin
            ptr_next = ptr_adv;
        end else if (ctrl.update) begin
            sum_next = sum_reg
                     - {{(SUM_W-2){old_value[1]}}, old_value}
                     + {{(SUM_W-2){ctrl.value[1]}}, ctrl.value};
            if (ptr_reg == PTR_LAST) begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= PTR_LAST;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            rd_reg <= mem[ptr_adv];
        end
        if (ctrl.update) begin
            mem[ptr_reg] <= ctrl.value;
        end
    end

    assign sum = $signed(sum_reg);

endmodule

// File: hw/rtl/emg_imj_div.sv
// restoring divider, one quotient bit per cycle, fractional quotient of num/den with num < den
module emg_imj_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [emg_imj_pkg::FRAC_W-1:0]   num,
    input  logic [emg_imj_pkg::TICKS_W-1:0]  den,
    output logic                             done,
    output logic [emg_imj_pkg::FRAC_W-1:0]   quot
);

    localparam int QW    = emg_imj_pkg::FRAC_W;
    localparam int DW    = emg_imj_pkg::TICKS_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [QW-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic [DW+1:0]    diff;
    logic             fits;

    assign trial = {rem_reg[DW-1:0], 1'b0};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[DW+1];

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {{(DW+1-QW){1'b0}}, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DW:0] : trial;
            quot_next = {quot_reg[QW-2:0], fits};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hw/rtl/emg_imj_mul.sv
// radix-4 shift-add multiplier, two multiplier bits per cycle, signed by unsigned
module emg_imj_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [emg_imj_pkg::MUL_AW-1:0] a,
    input  logic [emg_imj_pkg::MUL_BW-1:0]     b,
    output logic                               done,
    output logic [emg_imj_pkg::MUL_PW-1:0]     prod
);

    localparam int AW     = emg_imj_pkg::MUL_AW;
    localparam int BW     = emg_imj_pkg::MUL_BW;
    localparam int HW     = emg_imj_pkg::MUL_HW;
    localparam int DIGITS = BW / 2;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    logic [AW-1:0]    a_reg, a_next;
    logic [HW-1:0]    hi_reg, hi_next;
    logic [BW-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [HW-1:0]    a_ext, a_dbl, partial;

    assign a_ext   = {{(HW-AW){a_reg[AW-1]}}, a_reg};
    assign a_dbl   = {a_ext[HW-2:0], 1'b0};
    assign partial = hi_reg + (lo_reg[0] ? a_ext : '0) + (lo_reg[1] ? a_dbl : '0);

    always_comb begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // arithmetic shift of the partial product by one digit
            hi_next  = {{2{partial[HW-1]}}, partial[HW-1:2]};
            lo_next  = {partial[1:0], lo_reg[BW-1:2]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// File: hw/rtl/emg_intent_min_jerk_rise_core.sv
// top level: intent window, rise timer and serial minimum-jerk blend
//
//  channel   dir  handshake             payload
//  s_        in   s_tvalid / s_tready   s_tdata: intent_code, joint_angle; s_tuser: func
//  m_        out  m_tvalid / m_tready   m_tdata: desired_angle, exit_request, holding
//  cfg_      in   cfg_wr_en             cfg_index, cfg_wdata (hold, ticks, threshold)
//
// m_tvalid rises when the output state loads the result; a reset tick reaches it from the
// window state, other ticks via update and compare, a rising tick also via the divider (16
// steps) and four multiplies (10 radix-4 steps each, plus start state) sharing one unit.
// one tick is in flight at a time; the next is accepted while a result still waits in the
// output register, and a second result stalls in the output state until m_tready.
// reset clears the window through a fill flag, so no clearing pass is needed.
module emg_intent_min_jerk_rise_core #(
    parameter int WINDOW_DEPTH = emg_imj_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,   // intent_code[7:0], joint_angle[23:8]
    input  logic [0:0]                            s_tuser,   // func[0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [23:0]                           m_tdata,   // desired_angle[15:0], exit_request[16],
                                                             // holding[17], zero[23:18]
    input  logic                                  cfg_wr_en,
    input  logic [emg_imj_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [emg_imj_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SUM_W   = $clog2(WINDOW_DEPTH + 1) + 1;
    localparam int ANGLE_W = emg_imj_pkg::ANGLE_W;
    localparam int TICKS_W = emg_imj_pkg::TICKS_W;
    localparam int THR_W   = emg_imj_pkg::THR_W;
    localparam int CODE_W  = emg_imj_pkg::CODE_W;
    localparam int FRAC_W  = emg_imj_pkg::FRAC_W;
    localparam int MUL_AW  = emg_imj_pkg::MUL_AW;
    localparam int MUL_BW  = emg_imj_pkg::MUL_BW;
    localparam int MUL_PW  = emg_imj_pkg::MUL_PW;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_WIN  = 8'b0000_0010,
        ST_UPD  = 8'b0000_0100,
        ST_CMP  = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_MST  = 8'b0010_0000,
        ST_MUL  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        MUL_S2,
        MUL_S3,
        MUL_BLEND,
        MUL_SCALE
    } mul_sel_t;

    state_t             state_reg, state_next;
    mul_sel_t           sel_reg, sel_next;
    logic               func_reg, func_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [ANGLE_W-1:0] hold_reg, hold_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [TICKS_W-1:0] timer_reg, timer_next;
    logic [ANGLE_W-1:0] start_reg, start_next;
    logic [FRAC_W-1:0]  s_reg, s_next;
    logic [FRAC_W-1:0]  s2_reg, s2_next;
    logic [FRAC_W-1:0]  s3_reg, s3_next;
    logic [FRAC_W:0]    b_reg, b_next;
    logic [ANGLE_W-1:0] res_angle_reg, res_angle_next;
    logic               res_exit_reg, res_exit_next;
    logic               res_hold_reg, res_hold_next;
    logic               m_valid_reg, m_valid_next;
    logic [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic               out_exit_reg, out_exit_next;
    logic               out_hold_reg, out_hold_next;

    emg_imj_pkg::win_ctrl_t  win_ctrl;
    logic signed [SUM_W-1:0] win_sum;
    logic                    div_start, div_done;
    logic [FRAC_W-1:0]       div_quot;
    logic                    mul_start, mul_done;
    logic signed [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0]       mul_b;
    logic [MUL_PW-1:0]       mul_prod;

    logic [TICKS_W-1:0]      timer_inc;
    logic [SUM_W+THR_W-1:0]  sum_x, thr_x;
    logic                    rise_active;
    logic [1:0]              code_value;
    logic [ANGLE_W:0]        delta;
    logic [MUL_BW:0]         q_word;
    logic [MUL_BW-1:0]       b_raw;
    logic [2*FRAC_W-1:0]     rounded;

    emg_imj_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (win_ctrl),
        .sum    (win_sum)
    );

    emg_imj_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (timer_inc),
        .den    (ticks_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

    emg_imj_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    assign timer_inc   = (timer_reg == '1) ? timer_reg : timer_reg + TICKS_W'(1);
    assign sum_x       = {{THR_W{win_sum[SUM_W-1]}}, win_sum};
    assign thr_x       = {{SUM_W{thr_reg[THR_W-1]}}, thr_reg};
    assign rise_active = $signed(sum_x) <= $signed(thr_x);
    assign code_value  = (code_reg == emg_imj_pkg::CODE_PLANTARFLEX) ? emg_imj_pkg::WIN_MINUS :
                         (code_reg == emg_imj_pkg::CODE_DORSIFLEX)   ? emg_imj_pkg::WIN_PLUS  :
                                                                       emg_imj_pkg::WIN_ZERO;
    assign delta       = {hold_reg[ANGLE_W-1], hold_reg} - {start_reg[ANGLE_W-1], start_reg};
    // q = 10 - 15 s + 6 s^2 in Q16, always positive
    assign q_word      = emg_imj_pkg::Q_BASE
                       + (MUL_BW+1)'({s2_reg, 2'b00}) + (MUL_BW+1)'({s2_reg, 1'b0})
                       - (MUL_BW+1)'({s_reg, 4'b0000}) + (MUL_BW+1)'(s_reg);
    assign b_raw       = mul_prod[FRAC_W+MUL_BW-1:FRAC_W];
    assign rounded     = mul_prod[2*FRAC_W-1:0] + emg_imj_pkg::ROUND_HALF;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        func_next      = func_reg;
        code_next      = code_reg;
        angle_next     = angle_reg;
        hold_next      = hold_reg;
        ticks_next     = ticks_reg;
        thr_next       = thr_reg;
        timer_next     = timer_reg;
        start_next     = start_reg;
        s_next         = s_reg;
        s2_next        = s2_reg;
        s3_next        = s3_reg;
        b_next         = b_reg;
        res_angle_next = res_angle_reg;
        res_exit_next  = res_exit_reg;
        res_hold_next  = res_hold_reg;
        m_valid_next   = m_valid_reg;
        out_angle_next = out_angle_reg;
        out_exit_next  = out_exit_reg;
        out_hold_next  = out_hold_reg;
        win_ctrl       = '0;
        div_start      = 1'b0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                emg_imj_pkg::CFG_HOLD_ANGLE: begin
                    hold_next = cfg_wdata[ANGLE_W-1:0];
                end
                emg_imj_pkg::CFG_RISE_TICKS: begin
                    ticks_next = cfg_wdata[TICKS_W-1:0];
                end
                emg_imj_pkg::CFG_INTENT_THRESHOLD: begin
                    thr_next = cfg_wdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser[0];
                    code_next  = s_tdata[CODE_W-1:0];
                    angle_next = s_tdata[CODE_W+ANGLE_W-1:CODE_W];
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                if (func_reg) begin
                    win_ctrl.clear = 1'b1;
                    timer_next     = '0;
                    start_next     = angle_reg;
                    res_angle_next = angle_reg;
                    res_exit_next  = 1'b0;
                    res_hold_next  = 1'b0;
                    state_next     = ST_OUT;
                end else begin
                    win_ctrl.advance = 1'b1;
                    state_next       = ST_UPD;
                end
            end
            ST_UPD: begin
                win_ctrl.update = 1'b1;
                win_ctrl.value  = code_value;
                state_next      = ST_CMP;
            end
            ST_CMP: begin
                res_exit_next = 1'b0;
                res_hold_next = 1'b0;
                if (rise_active) begin
                    timer_next = timer_inc;
                    if (timer_inc < ticks_reg) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        res_angle_next = hold_reg;
                        res_hold_next  = 1'b1;
                        state_next     = ST_OUT;
                    end
                end else begin
                    res_angle_next = angle_reg;
                    res_exit_next  = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    s_next     = div_quot;
                    sel_next   = MUL_S2;
                    state_next = ST_MST;
                end
            end
            ST_MST: begin
                mul_start = 1'b1;
                unique case (sel_reg)
                    MUL_S2: begin
                        mul_a = MUL_AW'(s_reg);
                        mul_b = MUL_BW'(s_reg);
                    end
                    MUL_S3: begin
                        mul_a = MUL_AW'(s_reg);
                        mul_b = MUL_BW'(s2_reg);
                    end
                    MUL_BLEND: begin
                        mul_a = MUL_AW'(s3_reg);
                        mul_b = q_word[MUL_BW-1:0];
                    end
                    MUL_SCALE: begin
                        mul_a = {delta[ANGLE_W], delta};
                        mul_b = MUL_BW'(b_reg);
                    end
                    default: begin
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_MST;
                    unique case (sel_reg)
                        MUL_S2: begin
                            s2_next  = mul_prod[2*FRAC_W-1:FRAC_W];
                            sel_next = MUL_S3;
                        end
                        MUL_S3: begin
                            s3_next  = mul_prod[2*FRAC_W-1:FRAC_W];
                            sel_next = MUL_BLEND;
                        end
                        MUL_BLEND: begin
                            // blend weight saturates at one
                            b_next   = (b_raw > MUL_BW'(emg_imj_pkg::BLEND_ONE)) ?
                                       emg_imj_pkg::BLEND_ONE : b_raw[FRAC_W:0];
                            sel_next = MUL_SCALE;
                        end
                        MUL_SCALE: begin
                            res_angle_next = start_reg + rounded[2*FRAC_W-1:FRAC_W];
                            state_next     = ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_angle_next = res_angle_reg;
                    out_exit_next  = res_exit_reg;
                    out_hold_next  = res_hold_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= MUL_S2;
            m_valid_reg <= 1'b0;
            hold_reg    <= emg_imj_pkg::HOLD_ANGLE_RESET;
            ticks_reg   <= emg_imj_pkg::RISE_TICKS_RESET;
            thr_reg     <= emg_imj_pkg::INTENT_THRESHOLD_RESET;
            timer_reg   <= '0;
            start_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            hold_reg    <= hold_next;
            ticks_reg   <= ticks_next;
            thr_reg     <= thr_next;
            timer_reg   <= timer_next;
            start_reg   <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        code_reg      <= code_next;
        angle_reg     <= angle_next;
        s_reg         <= s_next;
        s2_reg        <= s2_next;
        s3_reg        <= s3_next;
        b_reg         <= b_next;
        res_angle_reg <= res_angle_next;
        res_exit_reg  <= res_exit_next;
        res_hold_reg  <= res_hold_next;
        out_angle_reg <= out_angle_next;
        out_exit_reg  <= out_exit_next;
        out_hold_reg  <= out_hold_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, out_hold_reg, out_exit_reg, out_angle_reg};

    // the divider and the shared multiplier only finish while the sequencer waits on them
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its wait state");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("result not presented after output load");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_exit_reg && out_hold_reg))
        else $error("exit and holding flagged together");

endmodule

// File: test/emg_intent_min_jerk_rise_core_tb.sv
// testbench for the emg intent rise core: scoreboarded random and directed ticks
module emg_intent_min_jerk_rise_core_tb;

    localparam int DEPTH = emg_imj_pkg::DEFAULT_WINDOW_DEPTH;

    typedef struct packed {
        logic        func;
        logic [7:0]  code;
        logic [15:0] angle;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] desired;
        logic               exit_req;
        logic               holding;
    } target_t;

    // own copy of the window, timer and registers; predicts one target per tick
    class rise_tracker;
        logic signed [1:0]  window [DEPTH];
        int unsigned        wr_ptr;
        int                 acc_sum;
        logic [15:0]        timer;
        logic signed [15:0] start_pos;
        logic signed [15:0] hold_pos;
        logic [15:0]        ticks;
        logic signed [7:0]  threshold;
        target_t            pending_targets [$];
        int unsigned        fail_count;

        function new();
            hold_pos   = emg_imj_pkg::HOLD_ANGLE_RESET;
            ticks      = emg_imj_pkg::RISE_TICKS_RESET;
            threshold  = emg_imj_pkg::INTENT_THRESHOLD_RESET;
            fail_count = 0;
            restart(16'sd0);
        endfunction

        function void restart(logic signed [15:0] angle);
            foreach (window[i]) window[i] = emg_imj_pkg::WIN_ZERO;
            wr_ptr    = DEPTH - 1;
            acc_sum   = 0;
            timer     = 16'd0;
            start_pos = angle;
        endfunction

        function void set_register(logic [emg_imj_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [emg_imj_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                emg_imj_pkg::CFG_HOLD_ANGLE:       hold_pos  = value;
                emg_imj_pkg::CFG_RISE_TICKS:       ticks     = value;
                emg_imj_pkg::CFG_INTENT_THRESHOLD: threshold = value[7:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] blend_target();
            longint unsigned s, s2, s3, q, b;
            longint          delta, p, pos;
            s  = ({48'd0, timer} << 16) / {48'd0, ticks};
            s2 = (s * s) >> 16;
            s3 = (s2 * s) >> 16;
            q  = (64'd10 << 16) + 64'd6 * s2 - 64'd15 * s;
            b  = (s3 * q) >> 16;
            if (b > 64'd65536) b = 64'd65536;
            delta = longint'(hold_pos) - longint'(start_pos);
            p     = delta * longint'(b);
            // round half up, floor towards minus infinity
            pos   = longint'(start_pos) + ((p + 64'sd32768) >>> 16);
            return pos[15:0];
        endfunction

        function void note_tick(logic func, logic [7:0] code, logic signed [15:0] angle);
            target_t           t;
            logic signed [1:0] c;
            t.desired  = angle;
            t.exit_req = 1'b0;
            t.holding  = 1'b0;
            if (func) begin
                restart(angle);
            end else begin
                wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
                acc_sum -= window[wr_ptr];
                c = emg_imj_pkg::WIN_ZERO;
                if (code == emg_imj_pkg::CODE_PLANTARFLEX) c = emg_imj_pkg::WIN_MINUS;
                else if (code == emg_imj_pkg::CODE_DORSIFLEX) c = emg_imj_pkg::WIN_PLUS;
                acc_sum += c;
                window[wr_ptr] = c;
                if (acc_sum <= threshold) begin
                    if (timer != 16'hffff) timer++;
                    if (timer < ticks) begin
                        t.desired = blend_target();
                    end else begin
                        t.desired = hold_pos;
                        t.holding = 1'b1;
                    end
                end else begin
                    t.exit_req = 1'b1;
                end
            end
            pending_targets.push_back(t);
        endfunction

        function void check_target(logic [23:0] data);
            target_t want;
            if (pending_targets.size() == 0) begin
                $error("unexpected result: desired_angle %0d", $signed(data[15:0]));
                fail_count++;
                return;
            end
            want = pending_targets.pop_front();
            if (data[15:0] !== want.desired) begin
                $error("desired_angle: expected %0d, actual %0d", want.desired,
                       $signed(data[15:0]));
                fail_count++;
            end
            if (data[16] !== want.exit_req) begin
                $error("exit_request: expected %0d, actual %0d", want.exit_req, data[16]);
                fail_count++;
            end
            if (data[17] !== want.holding) begin
                $error("holding: expected %0d, actual %0d", want.holding, data[17]);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_targets.size();
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [23:0]                         s_tdata;    // intent_code[7:0], joint_angle[23:8]
    logic [0:0]                          s_tuser;    // func[0]
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [23:0]                         m_tdata;    // desired_angle[15:0], exit_request[16],
                                                     // holding[17]
    logic                                cfg_wr_en;
    logic [emg_imj_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [emg_imj_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    rise_tracker tracker;
    int          send_idle_pct;
    int          recv_idle_pct;

    emg_intent_min_jerk_rise_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.note_tick(s_tuser[0], s_tdata[7:0], s_tdata[23:8]);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_target(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic tick_t make_tick(logic func, logic [7:0] code, logic [15:0] angle);
        tick_t t;
        t.func  = func;
        t.code  = code;
        t.angle = angle;
        return t;
    endfunction

    // valid stays high from one transaction to the next unless a gap is drawn
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.angle, t.code};
        s_tuser  <= t.func;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_reg(input logic [emg_imj_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [emg_imj_pkg::CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_register(idx, value);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        write_reg(emg_imj_pkg::CFG_INTENT_THRESHOLD, {{8{thr[7]}}, thr});
    endtask

    task automatic run_directed();
        // exit at default threshold, extreme angles and codes
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_DORSIFLEX, 16'h7fff));
        send_tick(make_tick(1'b0, 8'h80, 16'h8000));
        send_tick(make_tick(1'b0, 8'h7f, 16'h0000));
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_PLANTARFLEX, 16'h1234));
        send_tick(make_tick(1'b1, 8'hff, 16'h8000));
        // full-span rise, then hold
        write_reg(emg_imj_pkg::CFG_HOLD_ANGLE, 16'h7fff);
        write_reg(emg_imj_pkg::CFG_RISE_TICKS, 16'd4);
        write_threshold(8'd64);
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_PLANTARFLEX, 16'h5555));
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_DORSIFLEX, 16'haaaa));
        send_tick(make_tick(1'b0, 8'h01, 16'h0001));
        send_tick(make_tick(1'b0, 8'hff, 16'hffff));
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_PLANTARFLEX, 16'h00ff));
        send_tick(make_tick(1'b0, 8'h03, 16'hff00));
        // zero rise duration holds at once
        write_reg(emg_imj_pkg::CFG_RISE_TICKS, 16'd0);
        send_tick(make_tick(1'b0, 8'h55, 16'h0f0f));
        send_tick(make_tick(1'b0, 8'haa, 16'hf0f0));
        // slow downward rise from the top angle
        write_reg(emg_imj_pkg::CFG_HOLD_ANGLE, 16'h8000);
        write_reg(emg_imj_pkg::CFG_RISE_TICKS, 16'hffff);
        send_tick(make_tick(1'b1, 8'h00, 16'h7fff));
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_DORSIFLEX, 16'h3333));
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_PLANTARFLEX, 16'hcccc));
        send_tick(make_tick(1'b0, 8'hfe, 16'h8001));
        // thresholds outside the usual range
        write_threshold(8'h80);
        send_tick(make_tick(1'b0, emg_imj_pkg::CODE_PLANTARFLEX, 16'h7ffe));
        send_tick(make_tick(1'b0, 8'h40, 16'h4000));
        write_threshold(8'h7f);
        send_tick(make_tick(1'b0, 8'h20, 16'h2000));
    endtask

    task automatic pick_setting();
        logic [15:0] hold;
        logic [15:0] ticks;
        logic [7:0]  thr;
        case ($urandom_range(5))
            0: hold = 16'h8000;
            1: hold = 16'h7fff;
            default: hold = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0: ticks = 16'd0;
            1: ticks = 16'd1;
            2: ticks = 16'hffff;
            default: ticks = 16'($urandom_range(60, 2));
        endcase
        case ($urandom_range(7))
            0: thr = -8'sd64;
            1: thr = 8'sd64;
            2: thr = 8'h80;
            3: thr = 8'h7f;
            4: thr = emg_imj_pkg::INTENT_THRESHOLD_RESET;
            default: thr = 8'($urandom_range(128) - 64);
        endcase
        write_reg(emg_imj_pkg::CFG_HOLD_ANGLE, hold);
        write_reg(emg_imj_pkg::CFG_RISE_TICKS, ticks);
        write_threshold(thr);
    endtask

    function automatic logic [7:0] draw_code(int plant_pct);
        int r;
        r = $urandom_range(99);
        if (r < plant_pct) return emg_imj_pkg::CODE_PLANTARFLEX;
        if (r < plant_pct + (100 - plant_pct) / 2) return emg_imj_pkg::CODE_DORSIFLEX;
        return 8'($urandom);
    endfunction

    // episodes: a reset tick, then a run of ticks biased towards one intent
    task automatic run_random_phase(input int n_items);
        int    sent;
        int    left;
        int    plant_pct;
        tick_t t;
        sent = 0;
        left = 0;
        plant_pct = 95;
        while (sent < n_items) begin
            if (left == 0) begin
                left = $urandom_range(200, 40);
                case ($urandom_range(2))
                    0: plant_pct = 95;
                    1: plant_pct = 75;
                    default: plant_pct = 40;
                endcase
                t = make_tick(1'b1, 8'($urandom), 16'($urandom));
            end else if ($urandom_range(99) < 4) begin
                t = make_tick(1'($urandom_range(1)), 8'($urandom), 16'($urandom));
            end else begin
                t = make_tick(1'b0, draw_code(plant_pct), 16'($urandom));
                left--;
            end
            send_tick(t);
            sent++;
            if ($urandom_range(199) == 0) wait_drained();
        end
    endtask

    initial begin
        int mode;
        int k;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        tracker = new();
        send_idle_pct = 8;
        recv_idle_pct = 72;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 8;  recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (k = 0; k < 4; k++) begin
                pick_setting();
                run_random_phase(135);
            end
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (tracker.fail_count == 0 && tracker.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/emg_imj_pkg.sv
hw/rtl/emg_imj_window.sv
hw/rtl/emg_imj_div.sv
hw/rtl/emg_imj_mul.sv
hw/rtl/emg_intent_min_jerk_rise_core.sv
test/emg_intent_min_jerk_rise_core_tb.sv
